### design/assert_macros.svh
// assertion macros shared by the decoder rtl
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BFD_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) else $error(msg);

// checked at every edge, reset included
`define BFD_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) expr) else $error(msg);

`endif

### design/bfd_pkg.sv
// shared types and constants for the battery frame decoder
// no dependencies
package bfd_pkg;

    localparam int FRAME_LENGTH_DEF = 13;
    // bytes 0..11 are the only ones decoding looks at
    localparam int DECODE_BYTES     = 12;

    localparam logic [7:0]  START_BYTE    = 8'hA5;
    localparam logic [7:0]  SECOND_BYTE   = 8'h01;
    localparam logic [7:0]  TYPE_STATUS   = 8'h90;
    localparam logic [7:0]  TYPE_CAPACITY = 8'h93;
    localparam logic [15:0] CURRENT_BIAS  = 16'd30000;

    localparam logic [15:0] DEF_CHARGE = 16'd100;
    localparam logic [7:0]  DEF_FET    = 8'd1;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_CAPACITY = 2'd1,
        KIND_OTHER    = 2'd2
    } t_kind;

    typedef logic [DECODE_BYTES-1:0][7:0] t_frame;

    typedef struct packed {
        logic [7:0]         discharge_fet;
        logic [7:0]         charge_fet;
        logic [23:0]        remaining_capacity;
        logic [15:0]        charge_tenths;
        logic signed [15:0] current_tenths;
        logic [15:0]        voltage_tenths;
        t_kind              frame_kind;
    } t_result;

endpackage

### design/bfd_decode.sv
// frame decode: maps the buffered frame bytes to one result by type byte
// depends on bfd_pkg
module bfd_decode (
    input  bfd_pkg::t_frame  i_frame,
    output bfd_pkg::t_result o_result
);
    import bfd_pkg::*;

    logic [15:0] raw_current;

    assign raw_current = {i_frame[8], i_frame[9]};

    always_comb begin
        o_result.frame_kind         = KIND_OTHER;
        o_result.voltage_tenths     = '0;
        o_result.current_tenths     = '0;
        o_result.charge_tenths      = DEF_CHARGE;
        o_result.remaining_capacity = '0;
        o_result.charge_fet         = DEF_FET;
        o_result.discharge_fet      = DEF_FET;
        case (i_frame[2])
            TYPE_STATUS: begin
                o_result.frame_kind     = KIND_STATUS;
                o_result.voltage_tenths = {i_frame[4], i_frame[5]};
                // wraps modulo 2^16, read back as two's complement
                o_result.current_tenths = $signed(16'(CURRENT_BIAS - raw_current));
                o_result.charge_tenths  = {i_frame[10], i_frame[11]};
            end
            TYPE_CAPACITY: begin
                o_result.frame_kind         = KIND_CAPACITY;
                o_result.remaining_capacity = {i_frame[9], i_frame[10], i_frame[11]};
                o_result.charge_fet         = i_frame[5];
                o_result.discharge_fet      = i_frame[6];
            end
            default: begin
                o_result.frame_kind = KIND_OTHER;
            end
        endcase
    end

endmodule

### design/battery_frame_decoder_core.sv
// battery management unit frame decoder, top level
// depends on bfd_pkg, bfd_decode and assert_macros.svh
//
//  channel   dir  request contents
//  s_axis    in   tdata[7:0] rx_byte
//  m_axis    out  tuser[1:0] frame_kind; tdata[87:0] voltage, current, charge,
//                 remaining capacity, charge fet, discharge fet
//
// one byte is taken every cycle while s_axis is valid and ready; the byte counter and frame buffer update in that cycle
// the last byte of a frame is decoded the same cycle and its result is registered,
// so a result appears in the cycle after the closing byte is accepted
// s_axis stalls only while a result sits in the output register and m_axis is not ready
// synchronous active-low reset clears the byte counter and the output valid
`include "assert_macros.svh"

module battery_frame_decoder_core #(
    parameter int FRAME_LENGTH = bfd_pkg::FRAME_LENGTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,   // [7:0] rx_byte
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [87:0]                o_m_axis_tdata,   // [15:0] voltage_tenths,
                                                         // [31:16] current_tenths,
                                                         // [47:32] charge_tenths,
                                                         // [71:48] remaining_capacity,
                                                         // [79:72] charge_fet,
                                                         // [87:80] discharge_fet
    output logic [1:0]                 o_m_axis_tuser    // [1:0] frame_kind
);
    import bfd_pkg::*;

    localparam int          CNT_W    = $clog2(FRAME_LENGTH);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LENGTH - 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_buf [DECODE_BYTES];
    logic             r_m_valid;
    t_result          r_result;

    logic    accept;
    logic    keep_byte;
    logic    emit;
    t_frame  frame_view;
    t_result dec_result;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_count   = r_count;
        keep_byte = 1'b0;
        emit      = 1'b0;
        if (accept) begin
            if (r_count == '0 && i_s_axis_tdata != START_BYTE) begin
                n_count = '0;
            end else if (r_count == CNT_W'(1) && i_s_axis_tdata != SECOND_BYTE) begin
                // bad second byte drops the frame and is not retried as a start
                n_count = '0;
            end else begin
                keep_byte = 1'b1;
                if (r_count == LAST_POS) begin
                    emit    = 1'b1;
                    n_count = '0;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // buffer entries, plus a bypass so a short frame can close on a decoded byte
    for (genvar gi = 0; gi < DECODE_BYTES; gi++) begin : g_buf
        always_ff @(posedge i_clk) begin
            if (keep_byte && r_count == CNT_W'(gi)) begin
                r_buf[gi] <= i_s_axis_tdata;
            end
        end
        assign frame_view[gi] = (r_count == CNT_W'(gi)) ? i_s_axis_tdata : r_buf[gi];
    end

    bfd_decode u_decode (
        .i_frame  (frame_view),
        .o_result (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_result <= dec_result;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_result.frame_kind;
    assign o_m_axis_tdata  = {r_result.discharge_fet, r_result.charge_fet,
                              r_result.remaining_capacity, r_result.charge_tenths,
                              r_result.current_tenths, r_result.voltage_tenths};

    `BFD_ASSERT(a_emit_on_last, (r_m_valid && !$past(r_m_valid)) |-> $past(accept && r_count == LAST_POS), "result raised without a closing byte")
    `BFD_ASSERT(a_bad_second, (accept && r_count == CNT_W'(1) && i_s_axis_tdata != SECOND_BYTE) |=> (r_count == '0), "bad second byte did not drop the frame")
    `BFD_ASSERT(a_count_range, ({1'b0, r_count} <= {1'b0, LAST_POS}), "byte counter past frame end")
    `BFD_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> (r_count == '0 && !r_m_valid), "reset did not clear control state")

endmodule
